/* hw/rtl/mbps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared constants, register indexes and payload types of the scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // sizes fixed by the register and field layout
   localparam int ADDR_W         = 48;
   localparam int LEN_W          = 5;
   localparam int PATTERN_BYTES  = 16;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;

   // parameter defaults
   localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
   localparam int DEFAULT_OFFSET_WIDTH      = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE    = 3'd4;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // result item
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

   // live configuration, pattern length already clamped to the usable range
   typedef struct packed {
      logic [PATTERN_BYTES-1:0][7:0] pattern;
      logic [PATTERN_BYTES-1:0]      care_mask;
      logic [LEN_W-1:0]              pattern_length;
      logic [ADDR_W-1:0]             region_base;
   } cfg_type;

endpackage : mbps_pkg
`default_nettype wire

/* hw/rtl/masked_byte_pattern_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Finds the first occurrence of a wildcard byte signature in a byte stream
// and reports its address, or reports no match at the end of the region.
// ----------------------------------------------------------------------------
// Path: input register, then window compare, then result register.
// Throughput: one byte per cycle unless the result side stalls; the window
//   compare is combinational logic between the input and result registers.
// Reset: synchronous; clears window, byte count, match flag and registers
//   (pattern length resets to one); no clearing pass is needed.
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::DEFAULT_MAX_PATTERN_BYTES,
   parameter int OFFSET_WIDTH      = mbps_pkg::DEFAULT_OFFSET_WIDTH
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  mbps_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output mbps_pkg::rsp_type                 rsp_data,
   input  wire                               csr_we,
   input  wire  [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [mbps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbps_pkg::*;

   cfg_type cfg;
   logic    item_valid;
   req_type item;
   logic    advance;

   // configuration registers
   mbps_cfg_regs #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   mbps_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // window compare and result register
   mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .OFFSET_WIDTH      (OFFSET_WIDTH)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp_data)
   );

endmodule : masked_byte_pattern_scanner
`default_nettype wire

/* hw/rtl/mbps_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds pattern, care mask, length and region base; clamps the length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [mbps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [mbps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output mbps_pkg::cfg_type                    cfg
);
   import mbps_pkg::*;

   logic [63:0]        pattern_low_ff,  pattern_low_in;
   logic [63:0]        pattern_high_ff, pattern_high_in;
   logic [15:0]        care_mask_ff,    care_mask_in;
   logic [LEN_W-1:0]   length_ff,       length_in;
   logic [ADDR_W-1:0]  base_ff,         base_in;
   logic [LEN_W-1:0]   eff_length;

   // register write decode
   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      care_mask_in    = care_mask_ff;
      length_in       = length_ff;
      base_in         = base_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_in = csr_wdata;
            CSR_CARE_MASK:      care_mask_in    = csr_wdata[15:0];
            CSR_PATTERN_LENGTH: length_in       = csr_wdata[LEN_W-1:0];
            CSR_REGION_BASE:    base_in         = csr_wdata[ADDR_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '0;
         length_ff       <= LEN_W'(1);
         base_ff         <= '0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         care_mask_ff    <= care_mask_in;
         length_ff       <= length_in;
         base_ff         <= base_in;
      end
   end

   // zero length acts as one, anything above the window depth as the depth
   always_comb begin
      if (length_ff == '0) begin
         eff_length = LEN_W'(1);
      end else if (length_ff > LEN_W'(MAX_PATTERN_BYTES)) begin
         eff_length = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         eff_length = length_ff;
      end
   end

   assign cfg.pattern        = {pattern_high_ff, pattern_low_ff};
   assign cfg.care_mask      = care_mask_ff;
   assign cfg.pattern_length = eff_length;
   assign cfg.region_base    = base_ff;

endmodule : mbps_cfg_regs
`default_nettype wire

/* hw/rtl/mbps_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner input register
// Captures one byte per transfer and holds it until the match stage takes it.
// ----------------------------------------------------------------------------
module mbps_in_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  mbps_pkg::req_type   req,
   input  wire                 advance,
   output logic                item_valid,
   output mbps_pkg::req_type   item
);
   import mbps_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff,  data_in;
   logic    accept;

   // stage is blocked only while it holds an item the match stage cannot take
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req;
      end else begin
         valid_in = valid_ff && !advance;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

   // a held item stays put until the match stage takes it
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !advance |=> valid_ff && $stable(data_ff))
      else $error("input register lost or changed a held item");

endmodule : mbps_in_reg
`default_nettype wire

/* hw/rtl/mbps_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner match stage
// Shifts each byte into the window, compares under the care mask and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module mbps_match #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::DEFAULT_MAX_PATTERN_BYTES,
   parameter int OFFSET_WIDTH      = mbps_pkg::DEFAULT_OFFSET_WIDTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  mbps_pkg::cfg_type   cfg,
   input  wire                 item_valid,
   input  mbps_pkg::req_type   item,
   output logic                advance,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output mbps_pkg::rsp_type   rsp
);
   import mbps_pkg::*;

   localparam logic [OFFSET_WIDTH-1:0] COUNT_MAX = '1;

   logic [MAX_PATTERN_BYTES-1:0][7:0] win_ff, win_in, win_next;
   logic [OFFSET_WIDTH-1:0]           seen_ff, seen_in, seen_next;
   logic                              reported_ff, reported_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_type                           rsp_ff, rsp_in;
   logic [MAX_PATTERN_BYTES-1:0][7:0] sel_byte;
   logic [OFFSET_WIDTH-1:0]           offset;
   logic                              step, hit, match, emit;

   // a byte is processed once the result register is free for it
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step    = item_valid && advance;

   // window after this byte, newest at position zero
   always_comb begin
      win_next[0] = item.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         win_next[k] = win_ff[k-1];
      end
   end

   // saturating byte count
   assign seen_next = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;

   // pattern byte j lines up with window position length-1-j
   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         sel_byte[j] = '0;
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (k == int'(cfg.pattern_length) - 1 - j) begin
               sel_byte[j] = win_next[k];
            end
         end
         if (j < int'(cfg.pattern_length) && cfg.care_mask[j] &&
             sel_byte[j] != cfg.pattern[j]) begin
            hit = 1'b0;
         end
      end
   end

   assign match  = !reported_ff && (seen_next >= OFFSET_WIDTH'(cfg.pattern_length)) && hit;
   assign emit   = match || (item.last_byte && !reported_ff);
   assign offset = seen_next - OFFSET_WIDTH'(cfg.pattern_length);

   // region state, cleared after the last byte
   always_comb begin
      win_in      = win_ff;
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (step) begin
         if (item.last_byte) begin
            win_in      = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            win_in      = win_next;
            seen_in     = seen_next;
            reported_in = reported_ff || match;
         end
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step && emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.found         = match;
         rsp_in.match_address = match ? cfg.region_base + ADDR_W'(offset) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // nothing more is reported in a region once a match went out
   assert property (@(posedge clock) disable iff (reset)
      step && reported_ff |-> !emit)
      else $error("second result in one region");

   // a byte that is not the last one only ever reports a match
   assert property (@(posedge clock) disable iff (reset)
      step && emit && !item.last_byte |-> match)
      else $error("no-match result before end of region");

   // the last byte leaves the region state clean
   assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> seen_ff == '0 && !reported_ff)
      else $error("region state not cleared after last byte");

endmodule : mbps_match
`default_nettype wire

/* tb/sv/scan_match_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner match checker
// Watches the byte, result and register ports of the masked byte pattern
// scanner. It keeps its own copy of the registers, byte window and region
// count, predicts the match or no-match result that a byte transfer causes,
// if any, and compares each result transfer with the oldest one waiting.
// ----------------------------------------------------------------------------
module scan_match_check (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  mbps_pkg::req_type                  req_data,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  mbps_pkg::rsp_type                  rsp_data,
   input  wire                                csr_we,
   input  wire  [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [mbps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_results
);
   import mbps_pkg::*;

   localparam int WIN_BYTES = PATTERN_BYTES;
   localparam int COUNT_W   = DEFAULT_OFFSET_WIDTH;

   // register copies
   logic [127:0]               sig_bytes;
   logic [PATTERN_BYTES-1:0]   care_bits;
   logic [LEN_W-1:0]           sig_len;
   logic [ADDR_W-1:0]          base_addr;

   // region state
   logic [WIN_BYTES-1:0][7:0]  recent;
   logic [COUNT_W-1:0]         byte_count;
   logic                       reported;

   rsp_type                    awaited_hits[$];

   // length register as the block uses it
   function automatic int unsigned usable_len(input logic [LEN_W-1:0] raw);
      if (raw == '0)
         return 1;
      if (raw > PATTERN_BYTES)
         return PATTERN_BYTES;
      return raw;
   endfunction

   // shift one byte into the window and queue whatever result it causes
   task automatic advance_window(input logic [7:0] b, input logic last);
      int unsigned len;
      logic        hit;
      logic        produced;
      rsp_type     r;
      len = usable_len(sig_len);
      recent = {recent[WIN_BYTES-2:0], b};
      if (byte_count != '1)
         byte_count = byte_count + 1'b1;
      produced = 1'b0;
      if (!reported && byte_count >= COUNT_W'(len)) begin
         hit = 1'b1;
         // pattern byte j lines up with the byte that came j after the oldest
         for (int j = 0; j < len; j++) begin
            if (care_bits[j] && recent[len-1-j] != sig_bytes[8*j +: 8])
               hit = 1'b0;
         end
         if (hit) begin
            r.found         = 1'b1;
            r.match_address = base_addr + ADDR_W'(byte_count - COUNT_W'(len));
            awaited_hits.push_back(r);
            reported = 1'b1;
            produced = 1'b1;
         end
      end
      // end of region: report a miss if nothing was found, then start over
      if (last) begin
         if (!produced && !reported) begin
            r.found         = 1'b0;
            r.match_address = '0;
            awaited_hits.push_back(r);
         end
         recent     = '0;
         byte_count = '0;
         reported   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sig_bytes      = '0;
         care_bits      = '0;
         sig_len        = LEN_W'(1);
         base_addr      = '0;
         recent         = '0;
         byte_count     = '0;
         reported       = 1'b0;
         mismatch_count = 0;
         awaited_hits.delete();
      end else begin
         // result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (awaited_hits.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual found=%0b address=%h",
                        $time, rsp_data.found, rsp_data.match_address);
               mismatch_count++;
            end else begin
               if (rsp_data.found !== awaited_hits[0].found ||
                   rsp_data.match_address !== awaited_hits[0].match_address) begin
                  $display("%0t: result mismatch, expected found=%0b address=%h, actual found=%0b address=%h",
                           $time, awaited_hits[0].found, awaited_hits[0].match_address,
                           rsp_data.found, rsp_data.match_address);
                  mismatch_count++;
               end
               void'(awaited_hits.pop_front());
            end
         end

         // byte transfer
         if (req_valid && !req_stall)
            advance_window(req_data.data_byte, req_data.last_byte);

         // register writes apply from the next byte on
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_LOW:    sig_bytes[63:0]   = csr_wdata;
               CSR_PATTERN_HIGH:   sig_bytes[127:64] = csr_wdata;
               CSR_CARE_MASK:      care_bits         = csr_wdata[PATTERN_BYTES-1:0];
               CSR_PATTERN_LENGTH: sig_len           = csr_wdata[LEN_W-1:0];
               CSR_REGION_BASE:    base_addr         = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end
      end
      pending_results = awaited_hits.size();
   end

endmodule : scan_match_check

/* tb/sv/masked_byte_pattern_scanner_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner test
// Drives byte regions and register settings into the scanner, with random
// gaps on the byte side and random stalls on the result side, while the
// match checker predicts and compares every result. A directed opening
// covers the corner cases; random phases then plant the signature in most
// regions and leave the rest as noise or broken copies.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_test;
   import mbps_pkg::*;

   localparam int RANDOM_ITEMS     = 450;
   localparam int CALM_TAIL        = 50;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES    = 4;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                      mismatch_count;
   int                      pending_results;

   // stimulus side state
   logic                    calm = 1'b0;
   logic                    hold_wanted = 1'b0;
   logic                    sender_gaps = 1'b0;
   int                      bytes_sent = 0;
   logic [7:0]              region_bytes[$];
   logic [127:0]            stim_pattern;
   logic [15:0]             stim_care;
   int                      stim_len;

   masked_byte_pattern_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scan_match_check match_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one byte, return at the edge where the transfer happens
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      @(negedge clock);
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.data_byte  <= b;
      req_data.last_byte  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
      if (bytes_sent >= RANDOM_ITEMS - CALM_TAIL)
         calm = 1'b1;
   endtask

   // whole region from region_bytes, last flag on the final byte
   task automatic send_region();
      sender_gaps = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < region_bytes.size(); i++)
         send_byte(region_bytes[i], i == region_bytes.size() - 1);
   endtask

   // stop offering, wait for every result, then let the pipeline drain
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // new signature, mask, length and base, extremes favored
   task automatic random_config();
      logic [LEN_W-1:0]  len_val;
      logic [15:0]       care_val;
      logic [ADDR_W-1:0] base_val;
      stim_pattern = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       len_val = LEN_W'(0);
         1:       len_val = LEN_W'(1);
         2:       len_val = LEN_W'(PATTERN_BYTES);
         3:       len_val = '1;
         4:       len_val = LEN_W'($urandom_range(0, 31));
         default: len_val = LEN_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
         0:       care_val = '0;
         1:       care_val = '1;
         default: care_val = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       base_val = '0;
         1:       base_val = '1;
         default: base_val = {16'($urandom), 32'($urandom)};
      endcase
      stim_care = care_val;
      if (len_val == '0)
         stim_len = 1;
      else if (len_val > PATTERN_BYTES)
         stim_len = PATTERN_BYTES;
      else
         stim_len = len_val;
      write_reg(CSR_PATTERN_LOW, stim_pattern[63:0]);
      write_reg(CSR_PATTERN_HIGH, stim_pattern[127:64]);
      write_reg(CSR_CARE_MASK, CSR_DATA_W'(care_val));
      write_reg(CSR_PATTERN_LENGTH, CSR_DATA_W'(len_val));
      write_reg(CSR_REGION_BASE, CSR_DATA_W'(base_val));
   endtask

   // mostly regions with the signature planted, some short, noisy or broken
   task automatic random_region();
      int n;
      int pos;
      int kind;
      int k;
      kind = $urandom_range(0, 9);
      if (kind == 0)
         n = $urandom_range(1, stim_len);
      else
         n = stim_len + $urandom_range(0, 12);
      region_bytes.delete();
      for (int i = 0; i < n; i++)
         region_bytes.push_back(8'($urandom));
      if (kind >= 2) begin
         pos = $urandom_range(0, n - stim_len);
         for (int j = 0; j < stim_len; j++) begin
            if (stim_care[j])
               region_bytes[pos + j] = stim_pattern[8*j +: 8];
         end
         // broken copy: flip one bit inside the planted bytes
         if (kind == 2) begin
            k = $urandom_range(0, stim_len - 1);
            region_bytes[pos + k] = region_bytes[pos + k] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
      send_region();
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int rate;
      int tick;
      rate = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && rate != 0 && $urandom_range(0, 7) < rate) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         tick++;
         if (tick % 40 == 0)
            rate = $urandom_range(0, 3);
      end
   end

   initial begin : stimulus
      logic pressure_done;
      pressure_done = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // settings after reset: one-byte all-wildcard signature hits at once
      region_bytes = '{8'hFF};
      send_region();
      settle();

      // four-byte signature found on the last byte, address wraps past the top
      write_reg(CSR_PATTERN_LOW, 64'hEFBE_ADDE);
      write_reg(CSR_CARE_MASK, 64'h000F);
      write_reg(CSR_PATTERN_LENGTH, 64'd4);
      write_reg(CSR_REGION_BASE, 64'hFFFF_FFFF_FFFF);
      region_bytes = '{8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
      send_region();
      // region shorter than the signature
      region_bytes = '{8'hDE, 8'hAD};
      send_region();
      settle();

      // zero length acts as one; bytes after the hit give nothing
      write_reg(CSR_PATTERN_LENGTH, 64'd0);
      write_reg(CSR_CARE_MASK, 64'h0001);
      write_reg(CSR_PATTERN_LOW, 64'h0);
      region_bytes = '{8'h55, 8'h00, 8'h00};
      send_region();
      settle();

      // signature changed in the middle of a region
      write_reg(CSR_PATTERN_LENGTH, 64'd2);
      write_reg(CSR_CARE_MASK, 64'h0003);
      write_reg(CSR_PATTERN_LOW, 64'h55AA);
      write_reg(CSR_REGION_BASE, 64'h1000);
      send_byte(8'hAA, 1'b0);
      settle();
      write_reg(CSR_PATTERN_LOW, 64'h55BB);
      region_bytes = '{8'h55, 8'hBB, 8'h55};
      send_region();
      settle();

      // random phases
      while (bytes_sent < RANDOM_ITEMS) begin
         random_config();
         if (!pressure_done && bytes_sent > 150) begin
            // long result hold-off while one-byte regions keep coming
            pressure_done = 1'b1;
            hold_wanted   = 1'b1;
            repeat (40) begin
               region_bytes = '{8'($urandom)};
               send_region();
            end
            settle();
         end
         repeat ($urandom_range(2, 8))
            random_region();
         settle();
      end

      repeat (10) @(negedge clock);
      if (pending_results != 0)
         $display("%0t: %0d expected results never arrived", $time, pending_results);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run time limit
   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule : masked_byte_pattern_scanner_test

/* sim.f */
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg_regs.sv
hw/rtl/mbps_in_reg.sv
hw/rtl/mbps_match.sv
hw/rtl/masked_byte_pattern_scanner.sv
tb/sv/scan_match_check.sv
tb/sv/masked_byte_pattern_scanner_test.sv
